// ----- rtl/imudr_pkg.sv -----
// Shared types, codes and helpers for the IMU dead-reckoning integrator.
// No dependencies; used by the multiplier unit and the core.
package imudr_pkg;

    localparam int MUL_W  = 28;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_FIX     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_TRACK = 2'd1;
    localparam logic [1:0] MODE_DR    = 2'd2;

    localparam logic [2:0] REG_BIAS_X   = 3'd0;
    localparam logic [2:0] REG_BIAS_Y   = 3'd1;
    localparam logic [2:0] REG_BIAS_Z   = 3'd2;
    localparam logic [2:0] REG_GRAVITY  = 3'd3;
    localparam logic [2:0] REG_DEADBAND = 3'd4;

    localparam logic [4:0] LAST_STEP = 5'd30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SEND
    } state_t;

    // Clamp a wide signed value into 48-bit two's complement.
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] max_v;
        logic signed [63:0] min_v;
        max_v = 64'sh0000_7FFF_FFFF_FFFF;
        min_v = -64'sh0000_8000_0000_0000;
        if (v > max_v) begin
            sat48 = max_v[47:0];
        end else if (v < min_v) begin
            sat48 = min_v[47:0];
        end else begin
            sat48 = v[47:0];
        end
    endfunction

endpackage

// ----- rtl/imudr_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on imudr_pkg for operand widths.
module imudr_mul import imudr_pkg::*; (
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod_reg
);

    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

// ----- rtl/imu_dead_reckoning_integrator_core.sv -----
// A sample in dead-reckoning mode runs a 31-step sequence on one shared 28x28
// multiplier stepped 29 times; every other command updates the state at the
// accepting edge. The result is offered the next cycle after the work ends and
// is held until the receiver is ready. One item is in flight at a time, so no
// new input is taken until the result is accepted. Reset (aresetn, synchronous,
// active low) restores the registers to their defaults, mode to idle and velocity
// and pose to zero.
module imu_dead_reckoning_integrator_core import imudr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // quat_w[15:0] quat_x[31:16] quat_y[47:32] quat_z[63:48]
    // accel_x[88:64] accel_y[113:89] accel_z[138:114] step_time[159:139]
    // fix_x[207:160] fix_y[255:208]
    input  logic [255:0] s_tdata,
    // command[1:0]
    input  logic [1:0]   s_tuser,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // pose_x[47:0] pose_y[95:48]
    output logic [95:0]  m_tdata,
    // mode[1:0]
    output logic [1:0]   m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // ---------------- configuration registers ----------------
    logic signed [18:0] bias_x_reg, bias_y_reg, bias_z_reg;
    logic [20:0]        gravity_reg;
    logic [17:0]        deadband_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_x_reg   <= 19'sd2153;
            bias_y_reg   <= -19'sd8175;
            bias_z_reg   <= 19'sd16821;
            gravity_reg  <= 21'd642908;
            deadband_reg <= 18'd19661;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BIAS_X:   bias_x_reg   <= pwdata[18:0];
                REG_BIAS_Y:   bias_y_reg   <= pwdata[18:0];
                REG_BIAS_Z:   bias_z_reg   <= pwdata[18:0];
                REG_GRAVITY:  gravity_reg  <= pwdata[20:0];
                REG_DEADBAND: deadband_reg <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    // Gravity only feeds world z, which is not integrated; it is read back only.
    always_comb begin
        case (cfg_idx)
            REG_BIAS_X:   prdata = 32'($signed(bias_x_reg));
            REG_BIAS_Y:   prdata = 32'($signed(bias_y_reg));
            REG_BIAS_Z:   prdata = 32'($signed(bias_z_reg));
            REG_GRAVITY:  prdata = 32'(gravity_reg);
            REG_DEADBAND: prdata = 32'(deadband_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- input field slicing ----------------
    logic signed [15:0] in_qw, in_qx, in_qy, in_qz;
    logic signed [24:0] in_ax, in_ay, in_az;
    logic [20:0]        in_dt;
    logic signed [47:0] in_fix_x, in_fix_y;
    logic [1:0]         in_cmd;

    assign in_qw    = s_tdata[15:0];
    assign in_qx    = s_tdata[31:16];
    assign in_qy    = s_tdata[47:32];
    assign in_qz    = s_tdata[63:48];
    assign in_ax    = s_tdata[88:64];
    assign in_ay    = s_tdata[113:89];
    assign in_az    = s_tdata[138:114];
    assign in_dt    = s_tdata[159:139];
    assign in_fix_x = s_tdata[207:160];
    assign in_fix_y = s_tdata[255:208];
    assign in_cmd   = s_tuser;

    // ---------------- state ----------------
    state_t             state_reg, state_next;
    logic [4:0]         step_reg;
    logic [1:0]         mode_reg;
    logic signed [47:0] vel_x_reg, vel_y_reg, pos_x_reg, pos_y_reg;

    // latched sample operands
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [26:0] cx_reg, cy_reg, cz_reg;
    logic [20:0]        dt_reg;

    // shared-unit work registers
    logic signed [31:0] qp_reg [9];
    logic signed [63:0] acc_reg;
    logic signed [63:0] term_reg;
    logic signed [35:0] ax_reg, ay_reg;

    logic in_xfer, out_xfer, start_run;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_SEND);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;
    assign start_run = in_xfer && (in_cmd == CMD_SAMPLE) && (mode_reg == MODE_DR);

    assign m_tdata = {pos_y_reg, pos_x_reg};
    assign m_tuser = mode_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_run) begin
                    state_next = ST_RUN;
                end else if (in_xfer) begin
                    state_next = ST_SEND;
                end
            end
            ST_RUN: begin
                if (step_reg == LAST_STEP) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (out_xfer) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RUN) begin
                step_reg <= step_reg + 5'd1;
            end else begin
                step_reg <= '0;
            end
        end
    end

    // ---------------- rotation matrix entries (Q2.28) ----------------
    localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;
    logic signed [34:0] r00, r01, r02, r10, r11, r12;

    always_comb begin
        r00 = ONE_Q28 - ((35'(qp_reg[0]) + 35'(qp_reg[1])) <<< 1);
        r01 = (35'(qp_reg[2]) - 35'(qp_reg[3])) <<< 1;
        r02 = (35'(qp_reg[4]) + 35'(qp_reg[5])) <<< 1;
        r10 = (35'(qp_reg[2]) + 35'(qp_reg[3])) <<< 1;
        r11 = ONE_Q28 - ((35'(qp_reg[6]) + 35'(qp_reg[1])) <<< 1);
        r12 = (35'(qp_reg[7]) - 35'(qp_reg[8])) <<< 1;
    end

    // ---------------- operand selection for the shared multiplier ----------------
    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [34:0]       r_cur;
    logic signed [26:0]       c_cur;
    logic signed [MUL_W-1:0]  dt_op;

    assign dt_op = MUL_W'($signed({1'b0, dt_reg}));

    always_comb begin
        r_cur = r00;
        c_cur = cx_reg;
        op_a  = '0;
        op_b  = '0;
        case (step_reg)
            5'd9, 5'd10:  begin r_cur = r00; c_cur = cx_reg; end
            5'd11, 5'd12: begin r_cur = r01; c_cur = cy_reg; end
            5'd13, 5'd14: begin r_cur = r02; c_cur = cz_reg; end
            5'd15, 5'd16: begin r_cur = r10; c_cur = cx_reg; end
            5'd17, 5'd18: begin r_cur = r11; c_cur = cy_reg; end
            5'd19, 5'd20: begin r_cur = r12; c_cur = cz_reg; end
            default: ;
        endcase
        // Quaternion products first, then matrix times vector in two halves
        // of each entry, then the time-step products (high part, low part).
        case (step_reg)
            5'd0: begin op_a = MUL_W'(qy_reg); op_b = MUL_W'(qy_reg); end
            5'd1: begin op_a = MUL_W'(qz_reg); op_b = MUL_W'(qz_reg); end
            5'd2: begin op_a = MUL_W'(qx_reg); op_b = MUL_W'(qy_reg); end
            5'd3: begin op_a = MUL_W'(qz_reg); op_b = MUL_W'(qw_reg); end
            5'd4: begin op_a = MUL_W'(qx_reg); op_b = MUL_W'(qz_reg); end
            5'd5: begin op_a = MUL_W'(qy_reg); op_b = MUL_W'(qw_reg); end
            5'd6: begin op_a = MUL_W'(qx_reg); op_b = MUL_W'(qx_reg); end
            5'd7: begin op_a = MUL_W'(qy_reg); op_b = MUL_W'(qz_reg); end
            5'd8: begin op_a = MUL_W'(qx_reg); op_b = MUL_W'(qw_reg); end
            5'd9, 5'd11, 5'd13, 5'd15, 5'd17, 5'd19: begin
                op_a = MUL_W'($signed({1'b0, r_cur[16:0]}));
                op_b = MUL_W'(c_cur);
            end
            5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20: begin
                op_a = MUL_W'($signed(r_cur[34:17]));
                op_b = MUL_W'(c_cur);
            end
            5'd21: begin op_a = $signed(vel_x_reg[47:20]); op_b = dt_op; end
            5'd22: begin op_a = MUL_W'($signed({1'b0, vel_x_reg[19:0]})); op_b = dt_op; end
            5'd23: begin op_a = $signed(vel_y_reg[47:20]); op_b = dt_op; end
            5'd24: begin op_a = MUL_W'($signed({1'b0, vel_y_reg[19:0]})); op_b = dt_op; end
            5'd25: begin op_a = MUL_W'($signed(ax_reg[35:20])); op_b = dt_op; end
            5'd26: begin op_a = MUL_W'($signed({1'b0, ax_reg[19:0]})); op_b = dt_op; end
            5'd27: begin op_a = MUL_W'($signed(ay_reg[35:20])); op_b = dt_op; end
            5'd28: begin op_a = MUL_W'($signed({1'b0, ay_reg[19:0]})); op_b = dt_op; end
            default: ;
        endcase
    end

    imudr_mul u_mul (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    // ---------------- accumulate stage (product of the previous step) ----------------
    logic signed [63:0] prod_ext, prod_hi_term, acc_round;
    logic signed [35:0] axis_q16;
    logic signed [36:0] axis_wide, lim_wide;
    logic signed [35:0] axis_db;
    logic [41:0]        lo_round;

    assign prod_ext     = 64'(prod_reg);
    assign prod_hi_term = prod_ext <<< 17;
    assign acc_round    = acc_reg + 64'sd134217728;
    assign axis_q16     = acc_round[63:28];
    assign axis_wide    = 37'(axis_q16);
    assign lim_wide     = $signed({19'd0, deadband_reg});
    // Drop an axis whose magnitude lies inside the deadband.
    assign axis_db      = (axis_wide > -lim_wide && axis_wide < lim_wide) ? '0 : axis_q16;
    assign lo_round     = (42'(prod_reg[40:0]) + 42'd524288) >> 20;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RUN) begin
            case (step_reg)
                5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9:
                    qp_reg[4'(step_reg - 5'd1)] <= prod_reg[31:0];
                5'd10, 5'd16: acc_reg <= prod_ext;
                5'd12, 5'd14, 5'd18, 5'd20: acc_reg <= acc_reg + prod_ext;
                5'd11, 5'd13, 5'd15, 5'd17, 5'd19, 5'd21: acc_reg <= acc_reg + prod_hi_term;
                5'd22, 5'd24, 5'd26, 5'd28: acc_reg <= prod_ext;
                5'd23, 5'd25, 5'd27, 5'd29: term_reg <= acc_reg + 64'(lo_round);
                default: ;
            endcase
            // Row sums are complete in the step after their last accumulate.
            if (step_reg == 5'd16) begin
                ax_reg <= axis_db;
            end
            if (step_reg == 5'd22) begin
                ay_reg <= axis_db;
            end
        end
    end

    // ---------------- sample latch and architectural state ----------------
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            qw_reg <= in_qw;
            qx_reg <= in_qx;
            qy_reg <= in_qy;
            qz_reg <= in_qz;
            cx_reg <= 27'(in_az) + 27'(bias_z_reg);
            cy_reg <= -(27'(in_ax) + 27'(bias_x_reg));
            cz_reg <= -(27'(in_ay) + 27'(bias_y_reg));
            dt_reg <= in_dt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end else if (in_xfer) begin
            case (in_cmd)
                CMD_FIX: begin
                    pos_x_reg <= in_fix_x;
                    pos_y_reg <= in_fix_y;
                    mode_reg  <= MODE_TRACK;
                end
                CMD_TIMEOUT: begin
                    if (mode_reg == MODE_TRACK) begin
                        vel_x_reg <= '0;
                        vel_y_reg <= '0;
                        mode_reg  <= MODE_DR;
                    end
                end
                default: ;
            endcase
        end else if (state_reg == ST_RUN) begin
            // Pose moves with the old velocity, then velocity takes the new accel.
            case (step_reg)
                5'd24: pos_y_reg <= sat48(64'(pos_y_reg) - term_reg);
                5'd26: pos_x_reg <= sat48(64'(pos_x_reg) - term_reg);
                5'd28: vel_x_reg <= sat48(64'(vel_x_reg) + term_reg);
                5'd30: vel_y_reg <= sat48(64'(vel_y_reg) + term_reg);
                default: ;
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while an item is in progress");

    a_sample_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        start_run |=> (state_reg == ST_RUN && step_reg == 5'd0))
        else $error("dead-reckoning sample did not start the sequencer");

    a_fix_enters_tracking: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && in_cmd == CMD_FIX) |=> (mode_reg == MODE_TRACK && m_tvalid))
        else $error("pose fix did not enter tracking");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (step_reg <= LAST_STEP))
        else $error("sequencer step out of range");

endmodule
